// ----- hdl/qmn_pkg.sv -----
`default_nettype none
package qmn_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COMP_W = 16;
  localparam int RES_BITS = 16;
  localparam int PROD_W = 34;
  localparam int MAG_W = 33;
  localparam int SQ_W = 66;
  localparam int SUM_W = 68;
  localparam int TW = (2 * FRAC_BITS + 70 > 104) ? 2 * FRAC_BITS + 70 : 104;
  localparam int FRONT_STAGES = 6;
  localparam int LANE_STAGES = RES_BITS + 1;
  localparam int LATENCY = FRONT_STAGES + LANE_STAGES;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [TW-1:0] wide_t;

endpackage
`default_nettype wire

// ----- hdl/qmn_lane.sv -----
`default_nettype none
module qmn_lane (
  input  wire logic          clk,
  input  wire qmn_pkg::wide_t d_in,
  input  wire qmn_pkg::wide_t u_in,
  input  wire qmn_pkg::wide_t s_in,
  input  wire logic          neg_in,
  output qmn_pkg::comp_t     res
);
  import qmn_pkg::*;

  wide_t                d_r   [0:RES_BITS];
  wide_t                u_r   [0:RES_BITS];
  wide_t                s_r   [0:RES_BITS];
  logic [RES_BITS-1:0]  m_r   [0:RES_BITS];
  logic                 neg_r [0:RES_BITS];
  comp_t                res_r;
  logic [RES_BITS-1:0]  mag_c;

  assign d_r[0]   = d_in;
  assign u_r[0]   = u_in;
  assign s_r[0]   = s_in;
  assign m_r[0]   = '0;
  assign neg_r[0] = neg_in;

  for (genvar i = 0; i < RES_BITS; i++) begin : g_stage
    localparam int K = RES_BITS - 1 - i;
    wide_t trial;
    assign trial = d_r[i] - (u_r[i] <<< (K + 2)) - (s_r[i] <<< (2 * K + 2));
    always_ff @(posedge clk) begin
      s_r[i+1]   <= s_r[i];
      neg_r[i+1] <= neg_r[i];
      if (!trial[TW-1]) begin
        d_r[i+1] <= trial;
        u_r[i+1] <= u_r[i] + (s_r[i] <<< (K + 1));
        m_r[i+1] <= m_r[i] | (RES_BITS'(1) << K);
      end else begin
        d_r[i+1] <= d_r[i];
        u_r[i+1] <= u_r[i];
        m_r[i+1] <= m_r[i];
      end
    end
  end

  always_comb begin
    mag_c = m_r[RES_BITS];
    if (neg_r[RES_BITS]) begin
      if (mag_c > 16'd32768) mag_c = 16'd32768;
    end else begin
      if (mag_c > 16'd32767) mag_c = 16'd32767;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= neg_r[RES_BITS] ? comp_t'(-mag_c) : comp_t'(mag_c);
  end

  assign res = res_r;
endmodule
`default_nettype wire

// ----- hdl/quaternion_multiply_normalize.sv -----
`default_nettype none
// Channel   Ports                                      Handshake
// request   in_a_x..in_a_w, in_b_x..in_b_w (s16 Q2.14) start, busy
// result    out_r_x..out_r_w (s16), out_zero_length    out_valid strobe
//
// One request may be taken every cycle; busy is always low.
// Each result follows its request through six front stages
// (products, sums, squares, length) and a seventeen-stage bit-per-stage root
// division in each of four lanes.
// Synchronous active-low reset clears the valid pipeline; data carries no reset.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_multiply_normalize (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire qmn_pkg::comp_t in_a_x,
  input  wire qmn_pkg::comp_t in_a_y,
  input  wire qmn_pkg::comp_t in_a_z,
  input  wire qmn_pkg::comp_t in_a_w,
  input  wire qmn_pkg::comp_t in_b_x,
  input  wire qmn_pkg::comp_t in_b_y,
  input  wire qmn_pkg::comp_t in_b_z,
  input  wire qmn_pkg::comp_t in_b_w,
  output logic                out_valid,
  output qmn_pkg::comp_t      out_r_x,
  output qmn_pkg::comp_t      out_r_y,
  output qmn_pkg::comp_t      out_r_z,
  output qmn_pkg::comp_t      out_r_w,
  output logic                out_zero_length
);
  import qmn_pkg::*;

  logic                       valid_r [0:LATENCY-1];
  logic                       zero_r  [0:LANE_STAGES];
  comp_t                      a_r [4];
  comp_t                      b_r [4];
  logic signed [31:0]         pp_r [16];
  logic signed [PROD_W-1:0]   p_r [4];
  logic [SQ_W-1:0]            sq_r [4];
  logic                       n4_r [4];
  logic [SQ_W-1:0]            sq5_r [4];
  logic                       n5_r [4];
  logic [SUM_W-1:0]           s5_r;
  wide_t                      d6_r [4];
  wide_t                      u6_r;
  wide_t                      s6_r;
  logic                       n6_r [4];
  comp_t                      res [4];
  logic [MAG_W-1:0]           mag_c [4];
  logic                       accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LATENCY; i++) valid_r[i] <= 1'b0;
    end else begin
      valid_r[0] <= accept;
      for (int i = 1; i < LATENCY; i++) valid_r[i] <= valid_r[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = p_r[i][PROD_W-1] ? MAG_W'(-p_r[i]) : MAG_W'(p_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    a_r[0] <= in_a_x; a_r[1] <= in_a_y; a_r[2] <= in_a_z; a_r[3] <= in_a_w;
    b_r[0] <= in_b_x; b_r[1] <= in_b_y; b_r[2] <= in_b_z; b_r[3] <= in_b_w;

    pp_r[0]  <= a_r[3] * b_r[0];
    pp_r[1]  <= a_r[0] * b_r[3];
    pp_r[2]  <= a_r[1] * b_r[2];
    pp_r[3]  <= a_r[2] * b_r[1];
    pp_r[4]  <= a_r[3] * b_r[1];
    pp_r[5]  <= a_r[1] * b_r[3];
    pp_r[6]  <= a_r[2] * b_r[0];
    pp_r[7]  <= a_r[0] * b_r[2];
    pp_r[8]  <= a_r[3] * b_r[2];
    pp_r[9]  <= a_r[2] * b_r[3];
    pp_r[10] <= a_r[0] * b_r[1];
    pp_r[11] <= a_r[1] * b_r[0];
    pp_r[12] <= a_r[3] * b_r[3];
    pp_r[13] <= a_r[0] * b_r[0];
    pp_r[14] <= a_r[1] * b_r[1];
    pp_r[15] <= a_r[2] * b_r[2];

    for (int i = 0; i < 3; i++) begin
      p_r[i] <= PROD_W'(pp_r[4*i]) + PROD_W'(pp_r[4*i+1]) + PROD_W'(pp_r[4*i+2])
              - PROD_W'(pp_r[4*i+3]);
    end
    p_r[3] <= PROD_W'(pp_r[12]) - PROD_W'(pp_r[13]) - PROD_W'(pp_r[14])
            - PROD_W'(pp_r[15]);

    for (int i = 0; i < 4; i++) begin
      sq_r[i]  <= SQ_W'(mag_c[i]) * SQ_W'(mag_c[i]);
      n4_r[i]  <= p_r[i][PROD_W-1];
      sq5_r[i] <= sq_r[i];
      n5_r[i]  <= n4_r[i];
    end
    s5_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);

    for (int i = 0; i < 4; i++) begin
      d6_r[i] <= (TW'(sq5_r[i]) << (2 * FRAC_BITS + 2)) - TW'(s5_r);
      n6_r[i] <= n5_r[i];
    end
    u6_r <= -TW'(s5_r);
    s6_r <= TW'(s5_r);

    zero_r[0] <= (s5_r == '0);
    for (int i = 1; i <= LANE_STAGES; i++) zero_r[i] <= zero_r[i-1];
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qmn_lane u_lane (
      .clk    (clk),
      .d_in   (d6_r[i]),
      .u_in   (u6_r),
      .s_in   (s6_r),
      .neg_in (n6_r[i]),
      .res    (res[i])
    );
  end

  assign out_valid       = valid_r[LATENCY-1];
  assign out_zero_length = zero_r[LANE_STAGES];
  assign out_r_x         = out_zero_length ? '0 : res[0];
  assign out_r_y         = out_zero_length ? '0 : res[1];
  assign out_r_z         = out_zero_length ? '0 : res[2];
  assign out_r_w         = out_zero_length ? '0 : res[3];

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && out_r_w == '0))
    else $error("zero length result not cleared");
endmodule
`default_nettype wire

// ----- tb/quaternion_multiply_normalize_tb.sv -----
`default_nettype none
module quaternion_multiply_normalize_tb;
  import qmn_pkg::*;

  typedef struct packed {
    comp_t ax, ay, az, aw, bx, by, bz, bw;
  } quat_pair_t;

  typedef struct packed {
    comp_t x, y, z, w;
    logic zero_len;
  } unit_quat_t;

  localparam int RANDOM_N = 900;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  comp_t in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  comp_t in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic out_valid;
  comp_t out_r_x, out_r_y, out_r_z, out_r_w;
  logic out_zero_length;

  quat_pair_t pending_requests[$];
  unit_quat_t expected_units[$];
  quat_pair_t driven_pair;
  int total_requests;
  int sent_count = 0;
  int idle_pct;
  int errors = 0;
  int cycles = 0;

  quaternion_multiply_normalize dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z), .in_a_w(in_a_w),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_b_w(in_b_w),
    .out_valid(out_valid), .out_r_x(out_r_x), .out_r_y(out_r_y),
    .out_r_z(out_r_z), .out_r_w(out_r_w), .out_zero_length(out_zero_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [127:0] abs_wide(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // Largest n (at most 32767, or 32768 for negative p) with sumsq * (2n-1)^2 <= 4 q^2, i.e. round half away from zero.
  function automatic comp_t scale_component(longint p, logic [127:0] sumsq);
    logic [127:0] q, rhs, odd;
    longint lo, hi, mid;
    q = abs_wide(p) << FRAC_BITS;
    rhs = (q * q) << 2;
    lo = 0;
    hi = (p < 0) ? 32768 : 32767;
    while (lo < hi) begin
      mid = (lo + hi + 1) >>> 1;
      odd = 128'(2 * mid - 1);
      if (sumsq * odd * odd <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return comp_t'((p < 0) ? -lo : lo);
  endfunction

  function automatic unit_quat_t normalized_product(quat_pair_t r);
    longint ax, ay, az, aw, bx, by, bz, bw;
    longint px, py, pz, pw;
    logic [127:0] sumsq;
    unit_quat_t u;
    ax = r.ax; ay = r.ay; az = r.az; aw = r.aw;
    bx = r.bx; by = r.by; bz = r.bz; bw = r.bw;
    px = aw * bx + ax * bw + ay * bz - az * by;
    py = aw * by + ay * bw + az * bx - ax * bz;
    pz = aw * bz + az * bw + ax * by - ay * bx;
    pw = aw * bw - ax * bx - ay * by - az * bz;
    sumsq = abs_wide(px) * abs_wide(px) + abs_wide(py) * abs_wide(py)
          + abs_wide(pz) * abs_wide(pz) + abs_wide(pw) * abs_wide(pw);
    u = '0;
    if (sumsq == 0) begin
      u.zero_len = 1'b1;
    end else begin
      u.x = scale_component(px, sumsq);
      u.y = scale_component(py, sumsq);
      u.z = scale_component(pz, sumsq);
      u.w = scale_component(pw, sumsq);
    end
    return u;
  endfunction

  function automatic comp_t random_component(int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(33) - 16);
      2: return comp_t'($urandom_range(32768) - 16384);
      default: return ($urandom_range(1)) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
    endcase
  endfunction

  function automatic quat_pair_t make_pair(comp_t ax, comp_t ay, comp_t az, comp_t aw,
                                           comp_t bx, comp_t by, comp_t bz, comp_t bw);
    quat_pair_t r;
    r.ax = ax; r.ay = ay; r.az = az; r.aw = aw;
    r.bx = bx; r.by = by; r.bz = bz; r.bw = bw;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_units.push_back(normalized_product(driven_pair));
        void'(pending_requests.pop_front());
        sent_count = sent_count + 1;
      end
      if (sent_count < total_requests / 4) idle_pct = 0;
      else if (sent_count < total_requests / 2) idle_pct = 84;
      else if (sent_count < 3 * total_requests / 4) idle_pct = 35;
      else idle_pct = 0;
      if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
        driven_pair = pending_requests[0];
        start <= 1'b1;
        in_a_x <= driven_pair.ax; in_a_y <= driven_pair.ay;
        in_a_z <= driven_pair.az; in_a_w <= driven_pair.aw;
        in_b_x <= driven_pair.bx; in_b_y <= driven_pair.by;
        in_b_z <= driven_pair.bz; in_b_w <= driven_pair.bw;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    unit_quat_t e;
    if (rst_n && out_valid) begin
      if (expected_units.size() == 0) begin
        $error("result with no request outstanding");
        errors = errors + 1;
      end else begin
        e = expected_units.pop_front();
        if (out_r_x !== e.x) begin
          $error("r_x expected %0d got %0d", e.x, out_r_x);
          errors = errors + 1;
        end
        if (out_r_y !== e.y) begin
          $error("r_y expected %0d got %0d", e.y, out_r_y);
          errors = errors + 1;
        end
        if (out_r_z !== e.z) begin
          $error("r_z expected %0d got %0d", e.z, out_r_z);
          errors = errors + 1;
        end
        if (out_r_w !== e.w) begin
          $error("r_w expected %0d got %0d", e.w, out_r_w);
          errors = errors + 1;
        end
        if (out_zero_length !== e.zero_len) begin
          $error("zero_length expected %0d got %0d", e.zero_len, out_zero_length);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    comp_t one, mx, mn;
    int mode;
    one = 16'sh4000;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    pending_requests.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_pair(0, 0, 0, 0, mx, mn, 1, -1));
    pending_requests.push_back(make_pair(mx, 5, mn, 7, 0, 0, 0, 0));
    pending_requests.push_back(make_pair(0, 0, 0, one, 0, 0, 0, one));
    pending_requests.push_back(make_pair(one, 0, 0, 0, 0, one, 0, 0));
    pending_requests.push_back(make_pair(0, 0, one, 0, one, 0, 0, 0));
    pending_requests.push_back(make_pair(mx, mx, mx, mx, mx, mx, mx, mx));
    pending_requests.push_back(make_pair(mn, mn, mn, mn, mn, mn, mn, mn));
    pending_requests.push_back(make_pair(mn, mx, mn, mx, mx, mn, mx, mn));
    pending_requests.push_back(make_pair(0, 0, 0, 1, 0, 0, 0, 1));
    pending_requests.push_back(make_pair(0, 0, 0, -1, 0, 0, 0, 1));
    pending_requests.push_back(make_pair(1, 1, 0, 0, 0, 0, 0, 1));
    pending_requests.push_back(make_pair(1, 1, 1, 1, 0, 0, 0, 1));
    pending_requests.push_back(make_pair(3, 4, 0, 0, 0, 0, 0, -1));
    pending_requests.push_back(make_pair(1, 2, 3, 4, -4, 3, -2, 1));
    pending_requests.push_back(make_pair(mn, 0, 0, 0, 0, 0, 0, mn));
    pending_requests.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_requests.push_back(make_pair(one, one, one, one, one, -one, one, -one));
    pending_requests.push_back(make_pair(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                                         16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555));
    pending_requests.push_back(make_pair(1, 0, 0, 0, 1, 0, 0, 0));
    for (int i = 0; i < RANDOM_N; i++) begin
      mode = $urandom_range(3);
      if ($urandom_range(19) == 0) begin
        pending_requests.push_back(make_pair(0, 0, 0, 0, random_component(0),
          random_component(0), random_component(0), random_component(0)));
      end else begin
        pending_requests.push_back(make_pair(random_component(mode), random_component(mode),
          random_component(mode), random_component(mode), random_component(mode),
          random_component(mode), random_component(mode), random_component(mode)));
      end
    end
    total_requests = pending_requests.size();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_requests.size() > 0 || expected_units.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/qmn_pkg.sv
hdl/qmn_lane.sv
hdl/quaternion_multiply_normalize.sv
tb/quaternion_multiply_normalize_tb.sv
